// ----- rtl/tss_pkg.sv -----
// Shared types and constants for the time-to-sample seek core.
// No dependencies; tss_dp, tss_ctrl, the top level and the checker use this package by scoped names.
`timescale 1ns / 1ps

package tss_pkg;

    // Table size default (top-level parameter default)
    localparam int TABLE_DEPTH_DEF = 256;

    // Field widths
    localparam int IDX_W    = 8;
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 27;
    localparam int ECNT_W   = 9;
    localparam int TIME_W   = 32;

    // Datapath widths: scaled product, ticks left after /1000, run span
    localparam int PROD_W = 63;
    localparam int REM_W  = 54;
    localparam int SEG_W  = 64;

    // Stream payload layout
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;
    localparam int IDX_LSB     = 0;
    localparam int LEN_LSB     = 8;
    localparam int DUR_LSB     = 40;
    localparam int TIME_LSB    = 72;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES = 2'd2;

    localparam logic [WORD_W-1:0] TIMESCALE_RST = 32'd44100;
    localparam logic [WORD_W-1:0] MS_PER_S      = 32'd1000;

    // Item kinds carried on tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SEEK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SDIV,
        ST_SWAIT,
        ST_RD,
        ST_SEG,
        ST_CMP,
        ST_RWAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FOUND,
        RES_PAST_END
    } res_kind_t;

    typedef enum logic {
        DIV_SCALE,
        DIV_RUN
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      ram_we;
        logic      load_time;
        logic      mul_load;
        logic      div_start;
        div_sel_t  div_sel;
        logic      rem_load;
        logic      walk_clear;
        logic      rd_en;
        logic      seg_load;
        logic      walk_advance;
        logic      res_load;
        res_kind_t res_kind;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seek_trivial;
        logic div_done;
        logic walk_end;
        logic hit;
        logic out_full;
    } dp_stat_t;

endpackage

// ----- rtl/tss_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies; used for the run-length and duration tables.
`timescale 1ns / 1ps

module tss_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read share the port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tss_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// No package dependency; instantiated by the seek datapath.
`timescale 1ns / 1ps

module tss_div #(
    parameter int N_W = 63,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dsr_reg, dsr_next;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;

    // One restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[D_W+1])
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/tss_dp.sv -----
// Seek datapath: config registers, run tables, scaling multiply, 1/1000 scaling,
// run walk, serial divider and output register. Depends on tss_pkg, tss_ram, tss_div.
`timescale 1ns / 1ps

module tss_dp #(
    parameter int TABLE_DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tss_pkg::dp_cmd_t                   cmd,
    output tss_pkg::dp_stat_t                  stat,
    input  logic [tss_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               cfg_valid,
    input  logic [tss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [tss_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Scaling by 1/1000: long division in 16-bit digits, each digit by reciprocal
    // multiply (exact for a 26-bit partial dividend with a 2^-36 scaled reciprocal)
    localparam int SC_DIG_W = 16;
    localparam int SC_STEPS = 4;
    localparam int SC_ACC_W = SC_DIG_W * SC_STEPS;
    localparam int SC_REM_W = 10;
    localparam int SC_V_W   = SC_REM_W + SC_DIG_W;
    localparam int SC_SHIFT = 36;
    localparam int SC_MUL_W = 53;
    localparam int SC_CNT_W = 2;
    localparam logic [26:0]         SC_RECIP = 27'd68719477;
    localparam logic [SC_CNT_W-1:0] SC_LAST  = SC_CNT_W'(SC_STEPS - 1);

    // Configuration
    logic [tss_pkg::WORD_W-1:0]   timescale_reg;
    logic [tss_pkg::ECNT_W-1:0]   entry_count_reg;
    logic [tss_pkg::SAMPLE_W-1:0] total_reg;

    // Seek state
    logic [tss_pkg::TIME_W-2:0]   time_reg;
    logic [tss_pkg::PROD_W-1:0]   prod_reg;
    logic [tss_pkg::REM_W-1:0]    rem_reg;
    logic [tss_pkg::SEG_W-1:0]    seg_reg;
    logic [tss_pkg::WORD_W-1:0]   acc_reg;
    logic [CW-1:0]                idx_reg;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [tss_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                         out_clamped_reg, out_clamped_next;

    // Input fields
    logic [tss_pkg::IDX_W-1:0]    entry_index;
    logic [tss_pkg::WORD_W-1:0]   run_length;
    logic [tss_pkg::WORD_W-1:0]   sample_duration;
    logic signed [tss_pkg::TIME_W-1:0] time_ms;

    // Tables
    logic                         wr_in_range;
    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [tss_pkg::WORD_W-1:0]   rd_len;
    logic [tss_pkg::WORD_W-1:0]   rd_dur;

    // Scaling unit
    logic                         scale_start;
    logic                         sc_busy_reg;
    logic                         sc_done_reg;
    logic [SC_CNT_W-1:0]          sc_cnt_reg;
    logic [SC_ACC_W-1:0]          sc_acc_reg;
    logic [SC_REM_W-1:0]          sc_rem_reg;
    logic [SC_V_W-1:0]            sc_v;
    logic [SC_MUL_W-1:0]          sc_prod;
    logic [SC_DIG_W-1:0]          sc_q;
    logic [SC_V_W-1:0]            sc_r;

    // Divider
    logic                         run_div_start;
    logic                         div_done;
    logic [tss_pkg::REM_W-1:0]    div_quo;

    // Result forming
    logic [tss_pkg::WORD_W-1:0]   found_sum;
    logic                         found_clip;
    logic [tss_pkg::SAMPLE_W-1:0] last_sample;

    assign entry_index     = s_tdata[tss_pkg::IDX_LSB +: tss_pkg::IDX_W];
    assign run_length      = s_tdata[tss_pkg::LEN_LSB +: tss_pkg::WORD_W];
    assign sample_duration = s_tdata[tss_pkg::DUR_LSB +: tss_pkg::WORD_W];
    assign time_ms         = s_tdata[tss_pkg::TIME_LSB +: tss_pkg::TIME_W];

    // Table write only for slots inside the table
    assign wr_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign ram_we      = cmd.ram_we && wr_in_range;
    assign ram_addr    = cmd.ram_we ? AW'(entry_index) : idx_reg[AW-1:0];

    tss_ram #(
        .WIDTH (tss_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (run_length),
        .rdata (rd_len)
    );

    tss_ram #(
        .WIDTH (tss_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_dur_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd_en),
        .addr  (ram_addr),
        .wdata (sample_duration),
        .rdata (rd_dur)
    );

    // Route the start: scaling unit for ms-to-tick, serial divider for the run offset
    assign scale_start   = cmd.div_start && (cmd.div_sel == tss_pkg::DIV_SCALE);
    assign run_div_start = cmd.div_start && (cmd.div_sel == tss_pkg::DIV_RUN);

    // One quotient digit per cycle: partial remainder with the next 16 dividend bits
    assign sc_v    = {sc_rem_reg, sc_acc_reg[SC_ACC_W-1 -: SC_DIG_W]};
    assign sc_prod = SC_MUL_W'(sc_v) * SC_MUL_W'(SC_RECIP);
    assign sc_q    = sc_prod[SC_SHIFT +: SC_DIG_W];
    assign sc_r    = sc_v - SC_V_W'(sc_q) * SC_V_W'(tss_pkg::MS_PER_S);

    // Scaling control: four digit steps, then a done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_busy_reg <= 1'b0;
            sc_done_reg <= 1'b0;
            sc_cnt_reg  <= '0;
        end
        else
        begin
            sc_done_reg <= sc_busy_reg && !scale_start && (sc_cnt_reg == SC_LAST);
            if (scale_start)
            begin
                sc_busy_reg <= 1'b1;
                sc_cnt_reg  <= '0;
            end
            else if (sc_busy_reg)
            begin
                sc_cnt_reg <= sc_cnt_reg + SC_CNT_W'(1);
                if (sc_cnt_reg == SC_LAST)
                begin
                    sc_busy_reg <= 1'b0;
                end
            end
        end
    end

    // Scaling data: shift dividend digits out the top, quotient digits in the bottom
    always_ff @(posedge clk)
    begin
        if (scale_start)
        begin
            sc_acc_reg <= SC_ACC_W'(prod_reg);
            sc_rem_reg <= '0;
        end
        else if (sc_busy_reg)
        begin
            sc_acc_reg <= {sc_acc_reg[SC_ACC_W-SC_DIG_W-1:0], sc_q};
            sc_rem_reg <= sc_r[SC_REM_W-1:0];
        end
    end

    tss_div #(
        .N_W (tss_pkg::REM_W),
        .D_W (tss_pkg::WORD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (run_div_start),
        .dividend (rem_reg),
        .divisor  (rd_dur),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Status back to the controller
    always_comb
    begin
        stat.seek_trivial = time_ms[tss_pkg::TIME_W-1] || (time_ms == '0) ||
                            (entry_count_reg == '0);
        stat.div_done     = div_done || sc_done_reg;
        stat.walk_end     = (16'(idx_reg) >= 16'(entry_count_reg)) ||
                            (16'(idx_reg) >= 16'(TABLE_DEPTH));
        stat.hit          = (tss_pkg::SEG_W'(rem_reg) < seg_reg);
        stat.out_full     = out_valid_reg && !m_tready;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timescale_reg   <= tss_pkg::TIMESCALE_RST;
            entry_count_reg <= '0;
            total_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tss_pkg::CFG_TIMESCALE:     timescale_reg   <= cfg_data;
                tss_pkg::CFG_ENTRY_COUNT:   entry_count_reg <= cfg_data[tss_pkg::ECNT_W-1:0];
                tss_pkg::CFG_TOTAL_SAMPLES: total_reg       <= cfg_data[tss_pkg::SAMPLE_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Seek working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_time)
        begin
            time_reg <= time_ms[tss_pkg::TIME_W-2:0];
        end
        if (cmd.mul_load)
        begin
            prod_reg <= tss_pkg::PROD_W'(time_reg) * tss_pkg::PROD_W'(timescale_reg);
        end
        if (cmd.rem_load)
        begin
            rem_reg <= sc_acc_reg[tss_pkg::REM_W-1:0];
        end
        else if (cmd.walk_advance)
        begin
            rem_reg <= rem_reg - seg_reg[tss_pkg::REM_W-1:0];
        end
        if (cmd.seg_load)
        begin
            seg_reg <= tss_pkg::SEG_W'(rd_len) * tss_pkg::SEG_W'(rd_dur);
        end
        if (cmd.walk_clear)
        begin
            acc_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.walk_advance)
        begin
            acc_reg <= acc_reg + rd_len;
            idx_reg <= idx_reg + CW'(1);
        end
    end

    // Form the result: offset inside the hit run, clamp to the last sample
    assign found_sum   = acc_reg + div_quo[tss_pkg::WORD_W-1:0];
    assign found_clip  = (found_sum >= tss_pkg::WORD_W'(total_reg));
    assign last_sample = (total_reg == '0) ? '0 : total_reg - tss_pkg::SAMPLE_W'(1);

    always_comb
    begin
        out_valid_next   = out_valid_reg && !m_tready;
        out_sample_next  = out_sample_reg;
        out_clamped_next = out_clamped_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
            unique case (cmd.res_kind)
                tss_pkg::RES_ZERO:
                begin
                    out_sample_next  = '0;
                    out_clamped_next = 1'b0;
                end
                tss_pkg::RES_FOUND:
                begin
                    out_sample_next  = found_clip ? last_sample :
                                       found_sum[tss_pkg::SAMPLE_W-1:0];
                    out_clamped_next = found_clip;
                end
                tss_pkg::RES_PAST_END:
                begin
                    out_sample_next  = last_sample;
                    out_clamped_next = 1'b1;
                end
                default:
                begin
                    out_sample_next  = '0;
                    out_clamped_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg  <= out_sample_next;
        out_clamped_reg <= out_clamped_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tss_pkg::OUT_TDATA_W'(out_sample_reg);
    assign m_tuser  = out_clamped_reg;

endmodule

// ----- rtl/tss_ctrl.sv -----
// Seek controller: issues table writes and sequences scaling, run walk, division and result load.
// Depends on tss_pkg; drives tss_dp through dp_cmd_t.
`timescale 1ns / 1ps

module tss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    output tss_pkg::dp_cmd_t   cmd,
    input  tss_pkg::dp_stat_t  stat
);

    tss_pkg::state_t    state_reg, state_next;
    tss_pkg::res_kind_t kind_reg, kind_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::ST_IDLE;
            kind_reg  <= tss_pkg::RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.div_sel  = tss_pkg::DIV_SCALE;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == tss_pkg::MODE_SEEK)
                    begin
                        cmd.load_time = 1'b1;
                        if (stat.seek_trivial)
                        begin
                            kind_next  = tss_pkg::RES_ZERO;
                            state_next = tss_pkg::ST_RESULT;
                        end
                        else
                        begin
                            state_next = tss_pkg::ST_MUL;
                        end
                    end
                    else
                    begin
                        cmd.ram_we = 1'b1;
                    end
                end
            end
            tss_pkg::ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = tss_pkg::ST_SDIV;
            end
            tss_pkg::ST_SDIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = tss_pkg::ST_SWAIT;
            end
            tss_pkg::ST_SWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.rem_load   = 1'b1;
                    cmd.walk_clear = 1'b1;
                    state_next     = tss_pkg::ST_RD;
                end
            end
            tss_pkg::ST_RD:
            begin
                if (stat.walk_end)
                begin
                    kind_next  = tss_pkg::RES_PAST_END;
                    state_next = tss_pkg::ST_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = tss_pkg::ST_SEG;
                end
            end
            tss_pkg::ST_SEG:
            begin
                cmd.seg_load = 1'b1;
                state_next   = tss_pkg::ST_CMP;
            end
            tss_pkg::ST_CMP:
            begin
                // Target inside this run: divide remaining ticks by its duration
                if (stat.hit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = tss_pkg::DIV_RUN;
                    state_next    = tss_pkg::ST_RWAIT;
                end
                else
                begin
                    cmd.walk_advance = 1'b1;
                    state_next       = tss_pkg::ST_RD;
                end
            end
            tss_pkg::ST_RWAIT:
            begin
                cmd.div_sel = tss_pkg::DIV_RUN;
                if (stat.div_done)
                begin
                    kind_next  = tss_pkg::RES_FOUND;
                    state_next = tss_pkg::ST_RESULT;
                end
            end
            tss_pkg::ST_RESULT:
            begin
                // Hold until the output register frees up
                if (!stat.out_full)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = tss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/time_to_sample_seek_core.sv -----
// Top level of the time-to-sample seek core: controller plus datapath.
// Depends on tss_pkg, tss_ctrl, tss_dp (and through it tss_ram, tss_div).
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: entry_index, run_length,
//                                                sample_duration, time_ms; tuser: mode
// m_axis    out        m_axis_tvalid/tready      tdata: sample_index; tuser: clamped
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// A write item leaves the input ready for the next item. A seek with time <= 0
// or an empty table goes straight to its result. Other seeks run the time-by-
// timescale multiply, a four-step reciprocal scaling by 1/1000, a walk over the
// runs up to the one holding the target (table read, multiply, compare per run)
// and a 54-step serial division for the in-run offset. A seek past the table
// end walks every run and returns the last sample, clamped.
// The run tables are not cleared by reset; a slot is undefined until written.
// A result waiting on m_axis holds the controller only at its final load.

module time_to_sample_seek_core #(
    parameter int TABLE_DEPTH = tss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] entry_index, [39:8] run_length, [71:40] sample_duration,
    // [103:72] time_ms
    input  logic [tss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [26:0] sample_index, [31:27] zero
    output logic [tss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] clamped
    output logic                                m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tss_pkg::dp_cmd_t  cmd;
    tss_pkg::dp_stat_t stat;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tuser  (s_axis_tuser),
        .s_tready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tss_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

endmodule

// ----- rtl/tss_chk.sv -----
// Port-level checker for the time-to-sample seek core, bound to the top level.
// Depends on tss_pkg and time_to_sample_seek_core.
`timescale 1ns / 1ps

module tss_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    logic seek_acc;
    logic write_acc;

    assign seek_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tss_pkg::MODE_SEEK);
    assign write_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tss_pkg::MODE_WRITE);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A seek blocks further items while it runs
    a_seek_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seek_acc |=> !s_axis_tready)
        else $error("item taken right after a seek");

    // A table write leaves the input open
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        write_acc |=> s_axis_tready)
        else $error("input closed after a table write");

    // No result appears in the cycle after a seek is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        seek_acc |=> !$rose(m_axis_tvalid))
        else $error("result came too early");

    // Sample index never exceeds 27 bits
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[tss_pkg::OUT_TDATA_W-1:tss_pkg::SAMPLE_W] == '0))
        else $error("sample index padding not zero");

endmodule

bind time_to_sample_seek_core tss_chk u_tss_chk (.*);

// ----- test/time_to_sample_seek_core_test.sv -----
// Self-checking testbench for time_to_sample_seek_core: run table writes, seeks, clamping.
// Depends on tss_pkg and the core RTL; an in-bench predictor supplies the expected samples.
`timescale 1ns / 1ps

module time_to_sample_seek_core_test;

    localparam int TABLE_DEPTH  = tss_pkg::TABLE_DEPTH_DEF;
    localparam int SAMPLE_W     = tss_pkg::SAMPLE_W;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_DRAIN = 16;
    localparam int SETTLE_END   = 1000;
    localparam logic [31:0] TIME_MAX     = 32'h7FFF_FFFF;
    localparam logic [26:0] SAMPLES_MAX  = 27'd100000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_index;
        logic                clamped;
    } seek_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [tss_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                               s_axis_tuser  = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [tss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tss_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [tss_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    // Predictor copy of the configuration and run table
    logic [31:0]          timescale_q     = tss_pkg::TIMESCALE_RST;
    logic [8:0]           entry_count_q   = '0;
    logic [26:0]          total_samples_q = '0;
    logic [31:0]          run_len_tab [TABLE_DEPTH];
    logic [31:0]          run_dur_tab [TABLE_DEPTH];

    seek_result_t         seek_results [$];
    seek_result_t         head_result;
    int                   fault_count = 0;
    int                   cycle_count = 0;
    int                   stall_left  = 0;
    bit                   src_gaps    = 1'b1;
    bit                   sink_stalls = 1'b1;

    time_to_sample_seek_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive result backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result item with the oldest predicted seek
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (seek_results.size() == 0)
            begin
                $error("result with no seek pending: sample_index %0d clamped %0d",
                       m_axis_tdata[SAMPLE_W-1:0], m_axis_tuser);
                fault_count++;
            end
            else
            begin
                head_result = seek_results.pop_front();
                if (m_axis_tdata[SAMPLE_W-1:0] !== head_result.sample_index)
                begin
                    $error("sample_index mismatch: expected %0d, actual %0d",
                           head_result.sample_index, m_axis_tdata[SAMPLE_W-1:0]);
                    fault_count++;
                end
                if (m_axis_tuser !== head_result.clamped)
                begin
                    $error("clamped mismatch: expected %0d, actual %0d",
                           head_result.clamped, m_axis_tuser);
                    fault_count++;
                end
            end
        end
    end

    // Walk the runs to find the sample that holds the seek time
    function automatic seek_result_t locate_sample(input logic [31:0] time_bits);
        seek_result_t found;
        int unsigned  runs;
        logic [63:0]  ticks_left;
        logic [63:0]  span;
        logic [63:0]  into;
        logic [31:0]  samples_before;
        logic [31:0]  pick;
        logic [31:0]  last_index;
        found      = '0;
        runs       = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : entry_count_q;
        last_index = (total_samples_q != 0) ? 32'(total_samples_q) - 32'd1 : 32'd0;
        if (time_bits[31] || time_bits == '0 || runs == 0)
            return found;
        ticks_left     = 64'(time_bits) * 64'(timescale_q) / 64'(tss_pkg::MS_PER_S);
        samples_before = '0;
        for (int i = 0; i < runs; i++)
        begin
            span = 64'(run_len_tab[i]) * 64'(run_dur_tab[i]);
            if (ticks_left < span)
            begin
                // span above zero here, so the duration is nonzero
                into          = ticks_left / 64'(run_dur_tab[i]);
                pick          = samples_before + into[31:0];
                found.clamped = (pick >= 32'(total_samples_q));
                if (found.clamped)
                    pick = last_index;
                found.sample_index = pick[SAMPLE_W-1:0];
                return found;
            end
            ticks_left     = ticks_left - span;
            samples_before = samples_before + run_len_tab[i];
        end
        // target lies past the last run
        found.sample_index = last_index[SAMPLE_W-1:0];
        found.clamped      = 1'b1;
        return found;
    endfunction

    // Time in ms covered by the first runs, saturated to the largest positive time
    function automatic logic [31:0] reach_ms(input int unsigned runs);
        logic [95:0] ticks;
        ticks = '0;
        for (int i = 0; i < runs && i < TABLE_DEPTH; i++)
            ticks = ticks + 96'(run_len_tab[i]) * 96'(run_dur_tab[i]);
        if (timescale_q == 0)
            return TIME_MAX;
        ticks = ticks * 96'(tss_pkg::MS_PER_S) / 96'(timescale_q);
        return (ticks > 96'(TIME_MAX)) ? TIME_MAX : ticks[31:0];
    endfunction

    // Mostly times inside the table, some past its end, some non-positive
    function automatic logic [31:0] pick_time(input int unsigned runs);
        logic [31:0] reach;
        reach = reach_ms(runs);
        case ($urandom_range(0, 9))
            0:       return $urandom | 32'h8000_0000;
            1:       return $urandom_range(0, 1) ? 32'd0 : TIME_MAX;
            2:       return $urandom & TIME_MAX;
            default: return $urandom_range(1, reach + reach / 8 + 1);
        endcase
    endfunction

    function automatic void draw_run(output logic [31:0] len, output logic [31:0] dur);
        case ($urandom_range(0, 19))
            0:
            begin
                len = '0;
                dur = $urandom_range(1, 2048);
            end
            1:
            begin
                len = $urandom_range(1, 2000);
                dur = '0;
            end
            2:
            begin
                len = $urandom;
                dur = $urandom;
            end
            default:
            begin
                len = $urandom_range(1, 2000);
                dur = $urandom_range(1, 2048);
            end
        endcase
    endfunction

    // Send one item and update the predictor when it is taken
    task automatic send_item(input logic mode, input logic [7:0] slot, input logic [31:0] len,
                             input logic [31:0] dur, input logic [31:0] t_ms);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {t_ms, dur, len, slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (mode == tss_pkg::MODE_WRITE)
        begin
            run_len_tab[slot] = len;
            run_dur_tab[slot] = dur;
        end
        else
        begin
            seek_results.push_back(locate_sample(t_ms));
        end
    endtask

    // Unused fields carry random bits so the core must ignore them
    task automatic store_run(input logic [7:0] slot, input logic [31:0] len,
                             input logic [31:0] dur);
        send_item(tss_pkg::MODE_WRITE, slot, len, dur, $urandom);
    endtask

    task automatic seek_at(input logic [31:0] t_ms);
        send_item(tss_pkg::MODE_SEEK, 8'($urandom), $urandom, $urandom, t_ms);
    endtask

    // Hold the sender until every predicted result has come back
    task automatic hold_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (seek_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] reg_index,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_index)
            tss_pkg::CFG_TIMESCALE:     timescale_q     = value;
            tss_pkg::CFG_ENTRY_COUNT:   entry_count_q   = value[8:0];
            tss_pkg::CFG_TOTAL_SAMPLES: total_samples_q = value[26:0];
            default: ;
        endcase
    endtask

    // Let the core go idle, then write all three registers
    task automatic set_config(input logic [31:0] ts, input logic [8:0] entries,
                              input logic [26:0] total);
        hold_for_results();
        repeat (SETTLE_DRAIN) @(posedge clk);
        write_reg(tss_pkg::CFG_TIMESCALE, ts);
        write_reg(tss_pkg::CFG_ENTRY_COUNT, 32'(entries));
        write_reg(tss_pkg::CFG_TOTAL_SAMPLES, 32'(total));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset configuration: empty table, non-positive and extreme times
    task automatic test_empty_table();
        seek_at(32'd1000);
        seek_at(TIME_MAX);
        seek_at(32'hFFFF_FFFF);
        seek_at(32'h8000_0000);
        seek_at(32'd0);
    endtask

    // Hand-built runs: zero length, zero duration, clamping, wrap, timescale extremes
    task automatic test_special_runs();
        store_run(8'd0, 32'd3, 32'd10);
        store_run(8'd1, 32'd0, 32'd50);
        store_run(8'd2, 32'd5, 32'd0);
        store_run(8'd3, 32'd4, 32'd7);
        store_run(8'd4, 32'hFFFF_FFFF, 32'd0);
        store_run(8'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_config(32'd1000, 9'd4, 27'd12);
        seek_at(32'd5);
        seek_at(32'd29);
        seek_at(32'd30);
        seek_at(32'd57);
        seek_at(32'd58);
        seek_at(TIME_MAX);
        // result lands on the total and is clamped
        set_config(32'd1000, 9'd4, 27'd9);
        seek_at(32'd40);
        // zero total samples clamps everything to zero
        set_config(32'd1000, 9'd4, 27'd0);
        seek_at(32'd5);
        seek_at(32'd100);
        // zero timescale maps every positive time to tick zero
        set_config(32'd0, 9'd4, 27'd12);
        seek_at(32'd100);
        // sample count wraps through the huge zero-duration run
        set_config(32'hFFFF_FFFF, 9'd6, SAMPLES_MAX);
        seek_at(TIME_MAX);
        set_config(32'd1000, 9'd6, SAMPLES_MAX);
        seek_at(32'd58);
    endtask

    // Write every slot so later seeks never touch an unwritten entry
    task automatic test_table_fill();
        logic [31:0] len;
        logic [31:0] dur;
        for (int slot = 0; slot < TABLE_DEPTH; slot++)
        begin
            draw_run(len, dur);
            store_run(8'(slot), len, dur);
        end
    endtask

    // Full-depth walks, an oversized entry count, and a written zero count
    task automatic test_full_table();
        set_config(32'd44100, 9'd256, SAMPLES_MAX);
        repeat (4) seek_at(pick_time(TABLE_DEPTH));
        seek_at(TIME_MAX);
        set_config(32'd1, 9'd511, SAMPLES_MAX);
        repeat (2) seek_at(pick_time(TABLE_DEPTH));
        set_config(32'd48000, 9'd0, SAMPLES_MAX);
        seek_at(32'd5);
    endtask

    // One setting of the registers, then a mix of seeks and table rewrites
    task automatic run_phase(input int n_items, input int unsigned max_runs);
        logic [31:0]  ts;
        logic [26:0]  total;
        logic [63:0]  length_sum;
        logic [31:0]  len;
        logic [31:0]  dur;
        logic [7:0]   slot;
        int unsigned  runs;
        case ($urandom_range(0, 5))
            0:       ts = 32'd1;
            1:       ts = 32'hFFFF_FFFF;
            2:       ts = $urandom | 32'd1;
            default: ts = $urandom_range(8000, 192000);
        endcase
        runs = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, max_runs);
        length_sum = '0;
        for (int i = 0; i < runs; i++)
            length_sum = length_sum + 64'(run_len_tab[i]);
        case ($urandom_range(0, 7))
            0: total = '0;
            1: total = SAMPLES_MAX;
            2: total = 27'($urandom_range(0, 100000000));
            default:
            begin
                total = (length_sum >= 64'(SAMPLES_MAX)) ? SAMPLES_MAX : length_sum[26:0];
                if (total != 0 && $urandom_range(0, 2) == 0)
                    total = total - 27'd1;
            end
        endcase
        set_config(ts, 9'(runs), total);
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                hold_for_results();
            if ($urandom_range(0, 3) == 0)
            begin
                slot = (runs != 0 && $urandom_range(0, 1)) ? 8'($urandom_range(0, runs - 1))
                                                           : 8'($urandom_range(0, 255));
                draw_run(len, dur);
                store_run(slot, len, dur);
            end
            else
            begin
                seek_at(pick_time(runs));
            end
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 9; p++)
        begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            run_phase(38, (p == 4) ? TABLE_DEPTH : 16);
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_back_to_back();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        run_phase(40, 8);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_special_runs();
        test_table_fill();
        test_full_table();
        test_random_phases();
        test_back_to_back();

        hold_for_results();
        repeat (SETTLE_END) @(posedge clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_div.sv
rtl/tss_dp.sv
rtl/tss_ctrl.sv
rtl/time_to_sample_seek_core.sv
rtl/tss_chk.sv
test/time_to_sample_seek_core_test.sv
